### hw/rtl/ihex_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_pkg: shared types and constants of the Intel HEX record parser
// Request and result layouts, the classified character token passed from the
// front end to the record engine, result kinds, error codes and record types.
// ----------------------------------------------------------------------------
package ihex_pkg;

    localparam int POS_W = 10;
    localparam logic [POS_W-1:0] POS_MAX  = 10'd1023;
    localparam logic [POS_W-1:0] MIN_LINE = 10'd11;

    localparam int TOKEN_FIFO_DEPTH  = 2;
    localparam int RESULT_FIFO_DEPTH = 2;

    // result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_SHORT     = 3'd1;
    localparam logic [2:0] ERR_LENGTH    = 3'd2;
    localparam logic [2:0] ERR_CHECKSUM  = 3'd3;
    localparam logic [2:0] ERR_TYPE      = 3'd4;
    localparam logic [2:0] ERR_BAD_DIGIT = 3'd5;

    // record types
    localparam logic [7:0] RTYPE_DATA       = 8'd0;
    localparam logic [7:0] RTYPE_EOF        = 8'd1;
    localparam logic [7:0] RTYPE_EXT_SEGMENT = 8'd2;
    localparam logic [7:0] RTYPE_EXT_LINEAR  = 8'd4;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_stream;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [7:0]  data_byte;
        logic [7:0]  record_kind;
        logic [2:0]  error_code;
    } result_t;

    // one classified character
    typedef struct packed {
        logic       lead_cr;    // a held carriage return is absorbed first
        logic       take_char;  // the character itself is absorbed
        logic       hex_ok;     // character is a hex digit
        logic [3:0] nibble;     // its value (0 when not hex)
        logic       line_end;   // record ends after this token
    } token_t;

endpackage
`default_nettype wire

### hw/rtl/ihex_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_fifo: small synchronous queue
// Register array with wrap-around pointers and an occupancy count; push and
// pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module ihex_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/ihex_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_front: character classifier
// Decodes hex digits, spots line feed and carriage return, and holds a
// carriage return until the next character shows whether a line feed follows.
// ----------------------------------------------------------------------------
module ihex_front
    import ihex_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire item_t  item,
    output logic        full,
    input  wire logic   tok_full,
    output logic        tok_push,
    output token_t      tok
);

    localparam logic [7:0] ASCII_LF   = 8'h0A;
    localparam logic [7:0] ASCII_CR   = 8'h0D;
    localparam logic [7:0] ASCII_0    = 8'h30;
    localparam logic [7:0] ASCII_9    = 8'h39;
    localparam logic [7:0] ASCII_UP_A = 8'h41;
    localparam logic [7:0] ASCII_UP_F = 8'h46;
    localparam logic [7:0] ASCII_LO_A = 8'h61;
    localparam logic [7:0] ASCII_LO_F = 8'h66;

    logic       pending_reg, pending_next;
    logic       is_lf;
    logic       is_cr;
    logic       hex_ok;
    logic [3:0] nibble;

    assign full     = tok_full;
    assign tok_push = push && !tok_full;
    assign is_lf    = (item.ch == ASCII_LF);
    assign is_cr    = (item.ch == ASCII_CR);

    always_comb
    begin
        hex_ok = 1'b1;
        nibble = 4'h0;
        unique case (item.ch) inside
            [ASCII_0:ASCII_9]:       nibble = 4'(item.ch - ASCII_0);
            [ASCII_UP_A:ASCII_UP_F]: nibble = 4'(item.ch - ASCII_UP_A + 8'd10);
            [ASCII_LO_A:ASCII_LO_F]: nibble = 4'(item.ch - ASCII_LO_A + 8'd10);
            default:                 hex_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        tok.lead_cr   = pending_reg && !is_lf;
        tok.take_char = !is_lf && !is_cr;
        tok.hex_ok    = hex_ok;
        tok.nibble    = nibble;
        tok.line_end  = is_lf || item.end_of_stream;
        pending_next  = is_cr && !item.end_of_stream;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else if (tok_push)
        begin
            pending_reg <= pending_next;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/ihex_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_back: record engine
// Assembles bytes from tokens, tracks count, offset, type, checksum and the
// extended base, emits data bytes and checks each record at its line end.
// ----------------------------------------------------------------------------
module ihex_back
    import ihex_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire token_t tok,
    input  wire logic   tok_empty,
    output logic        tok_pop,
    input  wire logic   res_full,
    output logic        res_push,
    output result_t     res
);

    localparam logic [8:0] FLD_COUNT = 9'd0;
    localparam logic [8:0] FLD_OFS_H = 9'd1;
    localparam logic [8:0] FLD_OFS_L = 9'd2;
    localparam logic [8:0] FLD_TYPE  = 9'd3;
    localparam logic [8:0] FLD_DATA0 = 9'd4;
    localparam logic [8:0] FLD_EXT_L = 9'd5;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [3:0]       nib;
        logic [7:0]       count;
        logic [15:0]      offset;
        logic [7:0]       rtype;
        logic [7:0]       sum;
        logic [15:0]      ext;
        logic             bad;
    } line_t;

    typedef struct packed {
        line_t      s;
        logic       hit;
        logic [7:0] k;
        logic [7:0] b;
    } absorb_t;

    // one character into the line state
    function automatic absorb_t absorb(line_t s, logic ok, logic [3:0] v);
        absorb_t    r;
        logic [3:0] nv;
        logic [7:0] b;
        logic [8:0] idx;
        logic [8:0] k;
        r     = '0;
        r.s   = s;
        nv    = v;
        b     = '0;
        idx   = '0;
        k     = '0;
        if (s.pos != POS_MAX)
        begin
            r.s.pos = s.pos + 1'b1;
            if (s.pos != '0)
            begin
                if (!ok)
                begin
                    r.s.bad = 1'b1;
                    nv      = 4'h0;
                end
                if (s.pos[0])
                begin
                    r.s.nib = nv;
                end
                else
                begin
                    b       = {s.nib, nv};
                    r.s.sum = s.sum + b;
                    idx     = s.pos[POS_W-1:1] - 9'd1;
                    case (idx)
                        FLD_COUNT: r.s.count  = b;
                        FLD_OFS_H: r.s.offset = {b, 8'h00};
                        FLD_OFS_L: r.s.offset = s.offset | {8'h00, b};
                        FLD_TYPE:  r.s.rtype  = b;
                        default:
                        begin
                            if (idx <= FLD_EXT_L)
                            begin
                                r.s.ext = {s.ext[7:0], b};
                            end
                            k     = idx - FLD_DATA0;
                            r.hit = (s.rtype == RTYPE_DATA) && (k < {1'b0, s.count})
                                    && !r.s.bad;
                            r.k   = k[7:0];
                            r.b   = b;
                        end
                    endcase
                end
            end
        end
        return r;
    endfunction

    line_t       line_reg, line_next;
    logic [31:0] base_reg, base_next;
    logic        halted_reg, halted_next;

    absorb_t     a_cr;
    absorb_t     a_ch;
    line_t       l_cr;
    line_t       l_ch;
    logic        data_hit;
    logic [2:0]  err;
    logic [POS_W-1:0] need_len;
    logic        type_ok;
    logic [16:0] ofs_k;

    assign tok_pop = !tok_empty && !res_full;

    always_comb
    begin
        a_cr     = absorb(line_reg, 1'b0, 4'h0);
        l_cr     = tok.lead_cr ? a_cr.s : line_reg;
        a_ch     = absorb(l_cr, tok.hex_ok, tok.nibble);
        l_ch     = tok.take_char ? a_ch.s : l_cr;
        data_hit = tok.take_char && a_ch.hit;
        ofs_k    = {1'b0, l_ch.offset} + {9'h000, a_ch.k};

        need_len = {1'b0, l_ch.count, 1'b0} + MIN_LINE;
        type_ok  = (l_ch.rtype == RTYPE_DATA) || (l_ch.rtype == RTYPE_EOF) ||
                   (l_ch.rtype == RTYPE_EXT_SEGMENT) ||
                   (l_ch.rtype == RTYPE_EXT_LINEAR);
        if (l_ch.pos < MIN_LINE)       err = ERR_SHORT;
        else if (l_ch.bad)             err = ERR_BAD_DIGIT;
        else if (l_ch.pos != need_len) err = ERR_LENGTH;
        else if (l_ch.sum != 8'h00)    err = ERR_CHECKSUM;
        else if (!type_ok)             err = ERR_TYPE;
        else                           err = ERR_NONE;

        line_next   = line_reg;
        base_next   = base_reg;
        halted_next = halted_reg;
        res_push    = 1'b0;
        res         = '0;

        if (tok_pop && !halted_reg)
        begin
            if (tok.line_end)
            begin
                res_push        = 1'b1;
                res.kind        = (err != ERR_NONE) ? KIND_ERROR : KIND_RECORD;
                res.address     = base_reg + {16'h0000, l_ch.offset};
                res.record_kind = l_ch.rtype;
                res.error_code  = err;
                line_next       = '0;
                if (err != ERR_NONE)
                begin
                    halted_next = 1'b1;
                end
                else if (l_ch.rtype == RTYPE_EXT_SEGMENT)
                begin
                    base_next = {12'h000, l_ch.ext, 4'h0};
                end
                else if (l_ch.rtype == RTYPE_EXT_LINEAR)
                begin
                    base_next = {l_ch.ext, 16'h0000};
                end
            end
            else
            begin
                line_next = l_ch;
                if (data_hit)
                begin
                    res_push      = 1'b1;
                    res.kind      = KIND_DATA;
                    res.address   = base_reg + {15'h0000, ofs_k};
                    res.data_byte = a_ch.b;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg   <= '0;
            base_reg   <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            line_reg   <= line_next;
            base_reg   <= base_next;
            halted_reg <= halted_next;
        end
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written into a full queue");

    a_halt_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.kind == KIND_ERROR) |=> halted_reg)
        else $error("error result did not halt the engine");

    a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !res_push)
        else $error("result produced after halting");

    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.kind == KIND_DATA) |-> (res.error_code == ERR_NONE && !line_reg.bad))
        else $error("data byte emitted from a line with a bad digit");

endmodule
`default_nettype wire

### hw/rtl/intel_hex_record_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// intel_hex_record_parser: Intel HEX text stream to data bytes and record status
// Usage:
//   Input channel: one text character per request on item (ch, end_of_stream),
//   taken when push is high and full is low. Line feed or end_of_stream ends a
//   record; a carriage return right before the line end is dropped.
//   Result channel: queue style. While empty is low the oldest result sits on
//   result; it is taken when pop is high. Results are data bytes (kind 0, with
//   absolute address base+offset+index) and one status per record (kind 1
//   accepted, kind 2 error with error_code). Data bytes of a record that later
//   fails must be discarded by the consumer.
//   Throughput: one character per cycle, sustained, as long as results drain.
//   Path: a taken character is queued as a token; the engine writes its result
//   into the result queue at the edge that pops the token, and the result can
//   be popped after that edge.
//   Stall: if pop stays low, the result queue fills, the engine stops pulling
//   tokens, the token queue fills and full rises. Nothing is lost.
//   After an error all further characters are taken and ignored until reset.
//   Reset (rst_n low, asynchronous) empties both queues and clears the line
//   state, the extended base and the error halt.
// ----------------------------------------------------------------------------
module intel_hex_record_parser
    import ihex_pkg::*;
#(
    parameter int TOKEN_DEPTH  = TOKEN_FIFO_DEPTH,
    parameter int RESULT_DEPTH = RESULT_FIFO_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t item,
    output logic       full,
    input  wire logic  pop,
    output result_t    result,
    output logic       empty
);

    // front end -> token queue
    token_t                 fe_tok;
    logic                   fe_tok_push;
    logic                   tq_full;
    // token queue -> record engine
    logic [$bits(token_t)-1:0] tq_rdata;
    logic                   tq_empty;
    logic                   be_tok_pop;
    // record engine -> result queue
    result_t                be_res;
    logic                   be_res_push;
    logic                   rq_full;
    logic [$bits(result_t)-1:0] rq_rdata;

    ihex_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .tok_full (tq_full),
        .tok_push (fe_tok_push),
        .tok      (fe_tok)
    );

    // decouples character intake from the record engine
    ihex_fifo #(
        .WIDTH ($bits(token_t)),
        .DEPTH (TOKEN_DEPTH)
    ) u_tok_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fe_tok_push),
        .wdata (fe_tok),
        .full  (tq_full),
        .pop   (be_tok_pop),
        .rdata (tq_rdata),
        .empty (tq_empty)
    );

    ihex_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (token_t'(tq_rdata)),
        .tok_empty (tq_empty),
        .tok_pop   (be_tok_pop),
        .res_full  (rq_full),
        .res_push  (be_res_push),
        .res       (be_res)
    );

    // output queue: holds results while the consumer stalls
    ihex_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (be_res_push),
        .wdata (be_res),
        .full  (rq_full),
        .pop   (pop),
        .rdata (rq_rdata),
        .empty (empty)
    );

    assign result = result_t'(rq_rdata);

endmodule
`default_nettype wire

### bench/ihex_record_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_record_checker: result prediction and comparison for the HEX parser
// Watches both queue ports, predicts every result from the accepted
// characters and compares each popped result with the oldest prediction.
// ----------------------------------------------------------------------------
module ihex_record_checker
    import ihex_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire item_t   item,
    input  wire logic    full,
    input  wire logic    pop,
    input  wire result_t result,
    input  wire logic    empty,
    output int           fail_count,
    output int           outstanding
);

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // parser state
    logic [POS_W-1:0] line_pos;
    logic [3:0]       hi_nib;
    logic [7:0]       cnt_field;
    logic [15:0]      rec_offset;
    logic [7:0]       rec_type;
    logic [7:0]       run_sum;
    logic [31:0]      base;
    logic [15:0]      ext_val;
    logic             bad_hex;
    logic             cr_held;
    logic             halted;

    // data byte completed by the current character
    logic             data_hit;
    logic [31:0]      data_addr;
    logic [7:0]       data_val;

    result_t          pending_results[$];

    task automatic clear_line();
        line_pos   = '0;
        hi_nib     = '0;
        cnt_field  = '0;
        rec_offset = '0;
        rec_type   = '0;
        run_sum    = '0;
        ext_val    = '0;
        bad_hex    = 1'b0;
        cr_held    = 1'b0;
    endtask

    task automatic absorb_char(input logic [7:0] c);
        logic [POS_W-1:0] pos;
        logic [3:0]       v;
        logic [7:0]       b;
        int               idx;
        int               k;
        begin
            if (line_pos >= POS_MAX)
            begin
                return;
            end
            pos      = line_pos;
            line_pos = pos + 1'b1;
            // start code is never decoded
            if (pos == '0)
            begin
                return;
            end
            if (c >= "0" && c <= "9")
            begin
                v = 4'(c - "0");
            end
            else if (c >= "A" && c <= "F")
            begin
                v = 4'(c - "A" + 8'd10);
            end
            else if (c >= "a" && c <= "f")
            begin
                v = 4'(c - "a" + 8'd10);
            end
            else
            begin
                v       = 4'd0;
                bad_hex = 1'b1;
            end
            if (pos[0])
            begin
                hi_nib = v;
                return;
            end
            b       = {hi_nib, v};
            run_sum = run_sum + b;
            idx     = (int'(pos) - 2) / 2;
            case (idx)
                0: cnt_field = b;
                1: rec_offset = {b, 8'h00};
                2: rec_offset[7:0] = b;
                3: rec_type = b;
                default:
                begin
                    if (idx <= 5)
                    begin
                        ext_val = {ext_val[7:0], b};
                    end
                    k = idx - 4;
                    if (rec_type == RTYPE_DATA && k < int'(cnt_field) && !bad_hex && !data_hit)
                    begin
                        data_hit  = 1'b1;
                        data_addr = base + {16'h0000, rec_offset} + 32'(k);
                        data_val  = b;
                    end
                end
            endcase
        end
    endtask

    task automatic parse_char(input item_t it, output logic got, output result_t res);
        logic       line_end;
        logic [2:0] err;
        begin
            got = 1'b0;
            res = '0;
            if (halted)
            begin
                return;
            end
            data_hit = 1'b0;
            line_end = it.end_of_stream;
            if (it.ch == CH_LF)
            begin
                cr_held  = 1'b0;
                line_end = 1'b1;
            end
            else
            begin
                if (cr_held)
                begin
                    cr_held = 1'b0;
                    absorb_char(CH_CR);
                end
                if (it.ch == CH_CR)
                begin
                    if (!it.end_of_stream)
                    begin
                        cr_held = 1'b1;
                    end
                end
                else
                begin
                    absorb_char(it.ch);
                end
            end
            if (line_end)
            begin
                // a byte finishing on the line end is dropped
                data_hit = 1'b0;
                err      = ERR_NONE;
                if (line_pos < MIN_LINE)
                begin
                    err = ERR_SHORT;
                end
                else if (bad_hex)
                begin
                    err = ERR_BAD_DIGIT;
                end
                else if (int'(line_pos) != 2 * int'(cnt_field) + int'(MIN_LINE))
                begin
                    err = ERR_LENGTH;
                end
                else if (run_sum != 8'h00)
                begin
                    err = ERR_CHECKSUM;
                end
                else if (rec_type != RTYPE_DATA && rec_type != RTYPE_EOF &&
                         rec_type != RTYPE_EXT_SEGMENT &&
                         rec_type != RTYPE_EXT_LINEAR)
                begin
                    err = ERR_TYPE;
                end
                res.kind        = (err != ERR_NONE) ? KIND_ERROR : KIND_RECORD;
                res.address     = base + {16'h0000, rec_offset};
                res.data_byte   = 8'h00;
                res.record_kind = rec_type;
                res.error_code  = err;
                got             = 1'b1;
                if (err != ERR_NONE)
                begin
                    halted = 1'b1;
                end
                else if (rec_type == RTYPE_EXT_SEGMENT)
                begin
                    base = {12'h000, ext_val, 4'h0};
                end
                else if (rec_type == RTYPE_EXT_LINEAR)
                begin
                    base = {ext_val, 16'h0000};
                end
                clear_line();
            end
            else if (data_hit)
            begin
                res.kind        = KIND_DATA;
                res.address     = data_addr;
                res.data_byte   = data_val;
                res.record_kind = RTYPE_DATA;
                res.error_code  = ERR_NONE;
                got             = 1'b1;
            end
        end
    endtask

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    always @(posedge clk)
    begin : watch
        result_t want;
        result_t fresh;
        logic    got;
        logic    bad;
        if (!rst_n)
        begin
            clear_line();
            base     = '0;
            halted   = 1'b0;
            data_hit = 1'b0;
            pending_results.delete();
        end
        else
        begin
            // the popped result always belongs to an older request
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("%0t: unexpected result kind=%0d addr=%h data=%h type=%h err=%0d",
                                 $time, result.kind, result.address, result.data_byte,
                                 result.record_kind, result.error_code);
                    end
                end
                else
                begin
                    want = pending_results.pop_front();
                    bad  = (result.kind !== want.kind) ||
                           (result.address !== want.address) ||
                           (result.data_byte !== want.data_byte) ||
                           (result.record_kind !== want.record_kind) ||
                           (result.error_code !== want.error_code);
                    if (bad)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: mismatch exp kind=%0d addr=%h data=%h type=%h err=%0d",
                                     $time, want.kind, want.address, want.data_byte,
                                     want.record_kind, want.error_code);
                            $display("%0t:          got kind=%0d addr=%h data=%h type=%h err=%0d",
                                     $time, result.kind, result.address, result.data_byte,
                                     result.record_kind, result.error_code);
                        end
                    end
                end
            end
            if (push && !full)
            begin
                parse_char(item, got, fresh);
                if (got)
                begin
                    pending_results.push_back(fresh);
                end
            end
        end
        outstanding = pending_results.size();
    end

endmodule

### bench/tb_intel_hex_record_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_intel_hex_record_parser: stimulus and verdict for the Intel HEX parser
// Feeds HEX text one character per request: a few hand-built records at the
// address and value extremes, then a long run of random well-formed records
// with every line ending, and finally one broken record that halts the block,
// followed by ignored noise. Both queue sides idle in random bursts, and the
// result side holds off once long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_intel_hex_record_parser;
    import ihex_pkg::*;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // how a line is terminated
    typedef enum int {
        TERM_LF,        // plain line feed
        TERM_CRLF,      // carriage return dropped before the line feed
        TERM_EOS_LAST,  // end_of_stream rides on the checksum's last digit
        TERM_CR_EOS,    // lone carriage return carrying end_of_stream
        TERM_LF_EOS     // line feed carrying end_of_stream
    } line_end_e;

    // how a record is broken on purpose
    typedef enum int {
        FLAW_NONE,
        FLAW_SHORT,       // cut below the minimum line length
        FLAW_BAD_DIGIT,   // one digit replaced by a non-hex character
        FLAW_CR_INSIDE,   // carriage return in mid-line counts as a bad digit
        FLAW_LENGTH,      // two extra digits, checksum still fine
        FLAW_TRUNC_DATA,  // stream ends on the first data byte
        FLAW_CHECKSUM,    // one checksum bit flipped
        FLAW_LONG         // runs past the position counter's saturation
    } flaw_e;

    logic    clk;
    logic    rst_n;
    logic    push;
    item_t   item;
    logic    full;
    logic    pop;
    result_t result;
    logic    empty;
    int      fail_count;
    int      outstanding;

    // stimulus-to-receiver controls
    logic    calm;       // final stretch: no idling on either side
    logic    hold_go;    // asks the receiver for its one long hold-off
    int      chars_sent;

    intel_hex_record_parser DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .pop    (pop),
        .result (result),
        .empty  (empty)
    );

    ihex_record_checker record_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .item        (item),
        .full        (full),
        .pop         (pop),
        .result      (result),
        .empty       (empty),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hex digit with random letter case
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return "0" + 8'(n);
        end
        return ($urandom_range(0, 1) ? "a" : "A") + 8'(n) - 8'd10;
    endfunction

    // One request per call. Entered and left at a falling edge; push stays
    // high between back-to-back requests and only drops for an idle burst.
    task automatic send_char(input logic [7:0] c, input logic eos);
        int gap;
        begin
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 6);
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            push <= 1'b1;
            item <= '{ch: c, end_of_stream: eos};
            // full is read just after the edge, before the block updates it
            do
            begin
                @(posedge clk);
            end
            while (full);
            chars_sent++;
            @(negedge clk);
        end
    endtask

    // Builds one record as text, optionally broken, and sends it. The first
    // two payload bytes come from lead so extended records get a chosen value.
    task automatic send_record(input logic [7:0] rtype, input logic [15:0] off,
                               input int cnt, input logic [15:0] lead,
                               input line_end_e term, input flaw_e flaw);
        logic [7:0] fields[$];
        logic [7:0] chars[$];
        logic [7:0] total;
        logic [7:0] c;
        int         at;
        int         keep;
        line_end_e  how;
        begin
            how = term;
            fields.push_back(8'(cnt));
            fields.push_back(off[15:8]);
            fields.push_back(off[7:0]);
            fields.push_back(rtype);
            for (int i = 0; i < cnt; i++)
            begin
                if (i == 0)
                begin
                    fields.push_back(lead[15:8]);
                end
                else if (i == 1)
                begin
                    fields.push_back(lead[7:0]);
                end
                else
                begin
                    fields.push_back(8'($urandom_range(0, 255)));
                end
            end
            total = 8'h00;
            foreach (fields[i])
            begin
                total = total + fields[i];
            end
            fields.push_back(8'h00 - total);
            if (flaw == FLAW_CHECKSUM)
            begin
                fields[fields.size() - 1] ^= 8'(1 << $urandom_range(0, 7));
            end

            // start code is not checked, so it is sometimes any byte but LF
            if ($urandom_range(0, 4) == 0)
            begin
                do
                begin
                    c = 8'($urandom_range(0, 255));
                end
                while (c == CH_LF);
            end
            else
            begin
                c = ":";
            end
            chars.push_back(c);
            foreach (fields[i])
            begin
                chars.push_back(hex_digit(fields[i][7:4]));
                chars.push_back(hex_digit(fields[i][3:0]));
            end

            case (flaw)
                FLAW_LENGTH:
                begin
                    chars.push_back("0");
                    chars.push_back("0");
                end
                FLAW_SHORT:
                begin
                    keep = $urandom_range(0, 10);
                    while (chars.size() > keep)
                    begin
                        void'(chars.pop_back());
                    end
                    if (keep == 0 && how == TERM_EOS_LAST)
                    begin
                        how = TERM_LF;
                    end
                end
                FLAW_TRUNC_DATA:
                begin
                    // position 10 completes the first data byte
                    while (chars.size() > 11)
                    begin
                        void'(chars.pop_back());
                    end
                    how = TERM_EOS_LAST;
                end
                FLAW_BAD_DIGIT:
                begin
                    at = $urandom_range(1, chars.size() - 1);
                    do
                    begin
                        c = 8'($urandom_range(0, 255));
                    end
                    while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
                           (c >= "a" && c <= "f") || c == CH_LF || c == CH_CR);
                    chars[at] = c;
                end
                FLAW_CR_INSIDE:
                begin
                    // never the last character, where it would just be dropped
                    at = $urandom_range(1, chars.size() - 2);
                    chars[at] = CH_CR;
                end
                FLAW_LONG:
                begin
                    repeat (1100) chars.push_back(hex_digit(4'($urandom_range(0, 15))));
                end
                default:
                begin
                end
            endcase

            foreach (chars[i])
            begin
                send_char(chars[i], how == TERM_EOS_LAST && i == chars.size() - 1);
            end
            case (how)
                TERM_LF:
                begin
                    send_char(CH_LF, 1'b0);
                end
                TERM_CRLF:
                begin
                    send_char(CH_CR, 1'b0);
                    send_char(CH_LF, 1'b0);
                end
                TERM_CR_EOS:
                begin
                    send_char(CH_CR, 1'b1);
                end
                TERM_LF_EOS:
                begin
                    send_char(CH_LF, 1'b1);
                end
                default:
                begin
                end
            endcase
        end
    endtask

    // Result side: random pop bursts, one long hold-off on request, and a
    // steady pop in the final stretch. Exactly one pop update per falling edge.
    initial
    begin : receiver
        int   stall_left;
        logic hold_done;
        pop        = 1'b0;
        stall_left = 0;
        hold_done  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if (hold_go && !hold_done)
            begin
                // long enough for both internal queues to fill and full to rise
                hold_done  = 1'b1;
                stall_left = 79;
                pop <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int          start_count;
        int          pick;
        int          cnt;
        int          waited;
        logic [7:0]  rtype;
        logic [15:0] off;
        logic [15:0] lead;
        line_end_e   term;

        push       = 1'b0;
        item       = '0;
        rst_n      = 1'b0;
        calm       = 1'b0;
        hold_go    = 1'b0;
        chars_sent = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // ---- directed records ----
        // empty data record
        send_record(RTYPE_DATA, 16'h0000, 0, 16'h0000, TERM_LF, FLAW_NONE);
        // top linear base, then data at offset FFFF wraps past 32 bits
        send_record(RTYPE_EXT_LINEAR, 16'h0000, 2, 16'hFFFF, TERM_CRLF, FLAW_NONE);
        send_record(RTYPE_DATA, 16'hFFFF, 4, 16'hFF00, TERM_EOS_LAST, FLAW_NONE);
        // top segment base
        send_record(RTYPE_EXT_SEGMENT, 16'h0000, 2, 16'hFFFF, TERM_CR_EOS, FLAW_NONE);
        send_record(RTYPE_DATA, 16'hFFFF, 2, 16'h00FF, TERM_LF_EOS, FLAW_NONE);
        send_record(RTYPE_EOF, 16'h0000, 0, 16'h0000, TERM_LF, FLAW_NONE);
        // extended records shorter than two bytes pick up the checksum
        send_record(RTYPE_EXT_LINEAR, 16'h1234, 0, 16'h0000, TERM_CRLF, FLAW_NONE);
        send_record(RTYPE_EXT_SEGMENT, 16'h0000, 1, 16'hA500, TERM_LF, FLAW_NONE);
        send_record(RTYPE_EXT_LINEAR, 16'h0000, 2, 16'h0000, TERM_LF, FLAW_NONE);

        // ---- random well-formed records ----
        start_count = chars_sent;
        while (chars_sent < start_count + 500)
        begin
            if (!hold_go && chars_sent > start_count + 200)
            begin
                hold_go = 1'b1;
            end
            if (chars_sent > start_count + 400)
            begin
                calm = 1'b1;
            end
            pick = $urandom_range(0, 99);
            off  = ($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 8))
                                               : 16'($urandom_range(0, 65535));
            lead = 16'($urandom_range(0, 65535));
            term = line_end_e'($urandom_range(0, 4));
            if (pick < 60)
            begin
                rtype = RTYPE_DATA;
                // mostly short records, a rare one up to the full count
                cnt = ($urandom_range(0, 24) == 0) ? $urandom_range(17, 255)
                                                   : $urandom_range(0, 16);
            end
            else if (pick < 84)
            begin
                rtype = (pick < 72) ? RTYPE_EXT_LINEAR : RTYPE_EXT_SEGMENT;
                cnt   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : 2;
                if ($urandom_range(0, 3) == 0)
                begin
                    lead = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                end
            end
            else if (pick < 92)
            begin
                rtype = RTYPE_EOF;
                cnt   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
            end
            else
            begin
                // data right at the top of the offset range
                rtype = RTYPE_DATA;
                off   = 16'hFFFF - 16'($urandom_range(0, 3));
                cnt   = $urandom_range(1, 8);
            end
            send_record(rtype, off, cnt, lead, term, FLAW_NONE);
        end

        // ---- one breaking record; the block halts after it ----
        calm = 1'b1;
        off  = 16'($urandom_range(0, 65535));
        lead = 16'($urandom_range(0, 65535));
        term = line_end_e'($urandom_range(0, 4));
        case ($urandom_range(0, 8))
            0: send_record(RTYPE_DATA, off, $urandom_range(0, 8), lead, term, FLAW_SHORT);
            1: send_char(CH_LF, 1'($urandom_range(0, 1)));   // empty line
            2: send_record(RTYPE_DATA, off, $urandom_range(1, 8), lead, term, FLAW_BAD_DIGIT);
            3: send_record(RTYPE_DATA, off, $urandom_range(1, 8), lead, term, FLAW_CR_INSIDE);
            4: send_record(RTYPE_DATA, off, $urandom_range(0, 8), lead, term, FLAW_LENGTH);
            5: send_record(RTYPE_DATA, off, $urandom_range(2, 8), lead, term, FLAW_TRUNC_DATA);
            6: send_record(RTYPE_EXT_LINEAR, off, 2, lead, term, FLAW_CHECKSUM);
            7:
            begin
                rtype = 8'($urandom_range(3, 255));
                if (rtype == RTYPE_EXT_LINEAR)
                begin
                    rtype = 8'd3;
                end
                send_record(rtype, off, $urandom_range(0, 4), lead, term, FLAW_NONE);
            end
            default: send_record(RTYPE_DATA, off, 4, lead, TERM_LF, FLAW_LONG);
        endcase

        // ignored by the halted block, no results expected
        repeat (40) send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        push <= 1'b0;

        // drain, then give a stray result time to show up
        waited = 0;
        while (outstanding != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(negedge clk);

        if (fail_count == 0 && outstanding == 0)
        begin
            $display("PASS intel_hex_record_parser");
        end
        else
        begin
            $display("FAIL intel_hex_record_parser");
        end
        $finish;
    end

    // run-time ceiling, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("FAIL intel_hex_record_parser");
        $finish;
    end

endmodule
